// ===== hw/rtl/fxp_alu_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: opcodes, widths and the pipeline token type.
// Used by the interfaces, the divider cell, the divider chain and the top level.
`default_nettype none
package fxp_alu_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MODE_W        = 4;
  localparam int unsigned FRAC_BITS_DEF = 8;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_INC     = 4'd10,
    OP_DEC     = 4'd11,
    OP_MAX     = 4'd12,
    OP_MIN     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_t;

  // Result computed at entry, carried alongside the divider chain.
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dz;
    logic              cmp;
    logic [DATA_W-1:0] value;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fxp_alu_if.sv =====
// Valid/ready channel interfaces for the fixed-point ALU requests and results.
// Depends on fxp_alu_pkg.
`default_nettype none
interface fxp_alu_req_if import fxp_alu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fxp_alu_rsp_if import fxp_alu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     compare_true;
  logic                     divide_by_zero;
  modport source (output valid, value, compare_true, divide_by_zero, input ready);
  modport sink (input valid, value, compare_true, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fxp_alu_div_cell.sv =====
// Restoring-division cell: one quotient bit per cycle when enabled; passes state on.
// Depends on fxp_alu_pkg.
`default_nettype none
module fxp_alu_div_cell
  import fxp_alu_pkg::*;
#(
  parameter int unsigned NUM_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] in_rem,
  input  wire logic [NUM_W-1:0] in_quo,
  input  wire logic [DATA_W-1:0] in_den,
  input  wire side_t            in_side,
  output logic                  out_valid,
  output logic [NUM_W-1:0]      out_rem,
  output logic [NUM_W-1:0]      out_quo,
  output logic [DATA_W-1:0]     out_den,
  output side_t                 out_side
);

  logic [NUM_W:0] trial;
  logic [NUM_W:0] diff;

  always_comb begin
    trial = {in_rem, in_quo[NUM_W-1]};
    diff  = trial - {{(NUM_W+1-DATA_W){1'b0}}, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_den  <= in_den;
      out_side <= in_side;
      if (diff[NUM_W]) begin
        out_rem <= trial[NUM_W-1:0];
        out_quo <= {in_quo[NUM_W-2:0], 1'b0};
      end else begin
        out_rem <= diff[NUM_W-1:0];
        out_quo <= {in_quo[NUM_W-2:0], 1'b1};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fxp_alu_div_chain.sv =====
// Row of division cells, one quotient bit per cell, with a shared stall enable.
// Depends on fxp_alu_pkg and fxp_alu_div_cell.
`default_nettype none
module fxp_alu_div_chain
  import fxp_alu_pkg::*;
#(
  parameter int unsigned NUM_W = 40
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DATA_W-1:0] in_den,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output side_t                  out_side
);

  logic              v   [NUM_W+1];
  logic [NUM_W-1:0]  rem [NUM_W+1];
  logic [NUM_W-1:0]  quo [NUM_W+1];
  logic [DATA_W-1:0] den [NUM_W+1];
  side_t             sd  [NUM_W+1];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign quo[0] = in_num;
  assign den[0] = in_den;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fxp_alu_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_rem   (rem[i]),
      .in_quo   (quo[i]),
      .in_den   (den[i]),
      .in_side  (sd[i]),
      .out_valid(v[i+1]),
      .out_rem  (rem[i+1]),
      .out_quo  (quo[i+1]),
      .out_den  (den[i+1]),
      .out_side (sd[i+1])
    );
  end

  assign out_valid = v[NUM_W];
  assign out_quo   = quo[NUM_W];
  assign out_side  = sd[NUM_W];

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_q24_8_alu.sv =====
// Channel    Modport  Payload
// req        sink     mode, operand_a, operand_b
// rsp        source   value, compare_true, divide_by_zero
// Every request passes through 32 + FRACTION_BITS + 3 register stages: the operand register,
// the decode register, the row of division cells that yields one quotient bit per cell, and
// the output register; one request is taken per cycle while the output is not stalled.
// All operations take the same path, so results leave in request order.
// Reset (rst, synchronous) clears the valid bits of all stages.
// A stalled result holds the whole pipeline; ready falls only while the output is held.
// Top level of the Q24.8 ALU; depends on fxp_alu_pkg, fxp_alu_if and fxp_alu_div_chain.
`default_nettype none
module fixed_point_q24_8_alu
  import fxp_alu_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRAC_BITS_DEF
) (
  input wire logic         clk,
  input wire logic         rst,
  fxp_alu_req_if.sink      req,
  fxp_alu_rsp_if.source    rsp
);

  localparam int unsigned NUM_W = DATA_W + FRACTION_BITS;
  localparam int unsigned PROD_W = 2 * DATA_W;

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 1: operand register.
  logic              s1_valid;
  op_t               s1_op;
  logic signed [DATA_W-1:0] s1_a;
  logic signed [DATA_W-1:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
    end
    if (en) begin
      s1_op <= op_t'(req.mode);
      s1_a  <= req.operand_a;
      s1_b  <= req.operand_b;
    end
  end

  // Stage 2: everything but divide finishes here; multiply product registered.
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] s2_prod;
  logic              s2_valid;
  logic              s2_is_mul;
  side_t             s2_side;
  side_t             side_c;
  logic [NUM_W-1:0]  s2_num;
  logic [NUM_W-1:0]  num_c;
  logic [DATA_W-1:0] s2_den;
  logic [DATA_W-1:0] den_c;
  logic signed [NUM_W-1:0] wide_a;
  logic gt;
  logic lt;
  logic eq;

  assign prod   = PROD_W'(s1_a) * PROD_W'(s1_b);
  assign wide_a = NUM_W'(s1_a) <<< FRACTION_BITS;
  assign gt = s1_a > s1_b;
  assign lt = s1_a < s1_b;
  assign eq = s1_a == s1_b;

  always_comb begin
    side_c        = '0;
    side_c.neg    = s1_a[DATA_W-1] ^ s1_b[DATA_W-1];
    num_c         = wide_a[NUM_W-1] ? NUM_W'(-wide_a) : NUM_W'(wide_a);
    den_c         = s1_b[DATA_W-1] ? DATA_W'(-s1_b) : DATA_W'(s1_b);
    case (s1_op)
      OP_ADD:     side_c.value = s1_a + s1_b;
      OP_SUB:     side_c.value = s1_a - s1_b;
      OP_MUL:     side_c.value = '0;
      OP_DIV: begin
        side_c.is_div = (s1_b != '0);
        side_c.dz     = (s1_b == '0);
      end
      OP_GT:      side_c.cmp = gt;
      OP_LT:      side_c.cmp = lt;
      OP_GE:      side_c.cmp = !lt;
      OP_LE:      side_c.cmp = !gt;
      OP_EQ:      side_c.cmp = eq;
      OP_NE:      side_c.cmp = !eq;
      OP_INC:     side_c.value = s1_a + DATA_W'(1);
      OP_DEC:     side_c.value = s1_a - DATA_W'(1);
      OP_MAX:     side_c.value = gt ? s1_a : s1_b;
      OP_MIN:     side_c.value = lt ? s1_a : s1_b;
      OP_TOINT:   side_c.value = s1_a >>> FRACTION_BITS;
      OP_FROMINT: side_c.value = s1_a << FRACTION_BITS;
      default:    side_c.value = '0;
    endcase
    if (s1_op == OP_GT || s1_op == OP_LT || s1_op == OP_GE || s1_op == OP_LE ||
        s1_op == OP_EQ || s1_op == OP_NE) begin
      side_c.value = DATA_W'(side_c.cmp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_side   <= side_c;
      s2_num    <= num_c;
      s2_den    <= den_c;
      s2_prod   <= prod;
      s2_is_mul <= (s1_op == OP_MUL);
    end
  end

  // Multiply result folded in before entering the division row.
  side_t side_in;
  always_comb begin
    side_in = s2_side;
    if (s2_is_mul) begin
      side_in.value = s2_prod[FRACTION_BITS +: DATA_W];
    end
  end

  logic             ch_valid;
  logic [NUM_W-1:0] ch_quo;
  side_t            ch_side;

  fxp_alu_div_chain #(.NUM_W(NUM_W)) u_chain (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s2_valid),
    .in_num   (s2_num),
    .in_den   (s2_den),
    .in_side  (side_in),
    .out_valid(ch_valid),
    .out_quo  (ch_quo),
    .out_side (ch_side)
  );

  logic [NUM_W-1:0] quo_s;
  assign quo_s = ch_side.neg ? NUM_W'(-ch_quo) : ch_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= ch_valid;
    end
    if (en) begin
      rsp.value          <= ch_side.is_div ? quo_s[DATA_W-1:0] : ch_side.value;
      rsp.compare_true   <= ch_side.cmp;
      rsp.divide_by_zero <= ch_side.dz;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> rsp.value == '0 && !rsp.compare_true)
    else $error("divide by zero result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("request stalled without output stall");
`endif

endmodule
`default_nettype wire
